@@ hdl/mimo_multipath_channel_fir_core_macros.svh @@
// Assertion macros shared by the checker of the MIMO channel FIR core.
// Depends on i_clk and i_rst_n being visible in the scope of each use.
`ifndef MIMO_MULTIPATH_CHANNEL_FIR_CORE_MACROS_SVH
`define MIMO_MULTIPATH_CHANNEL_FIR_CORE_MACROS_SVH

// Plain property check, disabled while reset is held
`define MMCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define MMCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);

`endif

@@ hdl/mmcf_pkg.sv @@
// Types and constants of the MIMO channel FIR core.
// No dependencies; every other source file except the macro header imports it.
package mmcf_pkg;

    localparam int SMP_W      = 16;
    localparam int FRAC_SHIFT = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DAT_W  = 16;

    localparam logic [1:0] MODE_TAP   = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TX_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd3;

    localparam logic [15:0] GAIN_UNITY = 16'd32768;

    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_cplx;

    typedef struct packed {
        logic [1:0]              mode;
        logic [8:0]              tap_addr;
        logic signed [SMP_W-1:0] tap_re;
        logic signed [SMP_W-1:0] tap_im;
        logic signed [SMP_W-1:0] tx0_re;
        logic signed [SMP_W-1:0] tx0_im;
        logic signed [SMP_W-1:0] tx1_re;
        logic signed [SMP_W-1:0] tx1_im;
        logic signed [SMP_W-1:0] tx2_re;
        logic signed [SMP_W-1:0] tx2_im;
        logic signed [SMP_W-1:0] tx3_re;
        logic signed [SMP_W-1:0] tx3_im;
    } t_in_word;

    typedef struct packed {
        logic [1:0]              rx_index;
        logic signed [SMP_W-1:0] rx_re;
        logic signed [SMP_W-1:0] rx_im;
        logic                    last;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] addr;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_word;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
        logic zero;
    } t_mac_ctl;

endpackage

@@ hdl/mmcf_chan_if.sv @@
// Valid/ready channels of the MIMO channel FIR core: sample, result, config.
// Depends on mmcf_pkg for the word types.
interface mmcf_in_if;
    import mmcf_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmcf_out_if;
    import mmcf_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmcf_cfg_if;
    import mmcf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

@@ hdl/mmcf_mac.sv @@
// Complex multiply-accumulate unit: one tap times one sample per cycle.
// Depends on mmcf_pkg.
module mmcf_mac #(
    parameter int ACC_W = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mmcf_pkg::t_mac_ctl      i_ctl,
    input  mmcf_pkg::t_cplx         i_x,
    input  mmcf_pkg::t_cplx         i_c,
    output logic signed [ACC_W-1:0] o_acc_re,
    output logic signed [ACC_W-1:0] o_acc_im,
    output logic                    o_busy
);
    import mmcf_pkg::*;

    logic signed [2*SMP_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic                      r_v2;
    logic signed [ACC_W-1:0]   r_acc_re, r_acc_im;
    logic signed [2*SMP_W:0]   w_term_re, w_term_im;

    // Register the four partial products; a term past the history reads as zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.zero) begin
            r_p_rr <= '0;
            r_p_ii <= '0;
            r_p_ri <= '0;
            r_p_ir <= '0;
        end else begin
            r_p_rr <= i_x.re * i_c.re;
            r_p_ii <= i_x.im * i_c.im;
            r_p_ri <= i_x.re * i_c.im;
            r_p_ir <= i_x.im * i_c.re;
        end
    end

    assign w_term_re = (2*SMP_W+1)'(r_p_rr) - (2*SMP_W+1)'(r_p_ii);
    assign w_term_im = (2*SMP_W+1)'(r_p_ri) + (2*SMP_W+1)'(r_p_ir);

    // Accumulate the real and imaginary sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2     <= 1'b0;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else begin
            r_v2 <= i_ctl.valid;
            if (i_ctl.clear) begin
                r_acc_re <= '0;
                r_acc_im <= '0;
            end else if (r_v2) begin
                r_acc_re <= r_acc_re + ACC_W'(w_term_re);
                r_acc_im <= r_acc_im + ACC_W'(w_term_im);
            end
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;
    assign o_busy   = r_v2;

endmodule

@@ hdl/mmcf_scale.sv @@
// Gain scaling: sum times gain, floor shift back to Q1.15, saturate.
// Depends on mmcf_pkg. Done follows start through the valid registers r_v1 and r_v2.
module mmcf_scale #(
    parameter int ACC_W = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ACC_W-1:0]       i_acc_re,
    input  logic signed [ACC_W-1:0]       i_acc_im,
    input  logic [15:0]                   i_gain,
    output logic                          o_done,
    output logic signed [mmcf_pkg::SMP_W-1:0] o_re,
    output logic signed [mmcf_pkg::SMP_W-1:0] o_im
);
    import mmcf_pkg::*;

    localparam int LO_W = ACC_W / 2;
    localparam int HI_W = ACC_W - LO_W;
    localparam int V_W  = ACC_W + 17;
    localparam logic signed [V_W-1:0] Q_MAX = V_W'(32767);
    localparam logic signed [V_W-1:0] Q_MIN = V_W'(-32768);

    logic [LO_W+15:0]        r_lo_re, r_lo_im;
    logic signed [HI_W+16:0] r_hi_re, r_hi_im;
    logic                    r_v1, r_v2;
    logic signed [SMP_W-1:0] r_re, r_im;

    function automatic logic signed [SMP_W-1:0] f_finish(
        input logic signed [HI_W+16:0] hi,
        input logic [LO_W+15:0]        lo
    );
        logic signed [V_W-1:0] v;
        logic signed [V_W-1:0] q;
        v = (V_W'(hi) <<< LO_W) + V_W'(signed'({1'b0, lo}));
        q = v >>> FRAC_SHIFT;
        if (q > Q_MAX) begin
            q = Q_MAX;
        end else if (q < Q_MIN) begin
            q = Q_MIN;
        end
        return q[SMP_W-1:0];
    endfunction

    // Split each sum in halves so that no product grows past the multiplier width
    always_ff @(posedge i_clk) begin
        r_lo_re <= i_acc_re[LO_W-1:0] * i_gain;
        r_lo_im <= i_acc_im[LO_W-1:0] * i_gain;
        r_hi_re <= signed'(i_acc_re[ACC_W-1:LO_W]) * signed'({1'b0, i_gain});
        r_hi_im <= signed'(i_acc_im[ACC_W-1:LO_W]) * signed'({1'b0, i_gain});
        if (r_v1) begin
            r_re <= f_finish(r_hi_re, r_lo_re);
            r_im <= f_finish(r_hi_im, r_lo_im);
        end
    end

    // Track the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign o_done = r_v2;
    assign o_re   = r_re;
    assign o_im   = r_im;

endmodule

@@ hdl/mimo_multipath_channel_fir_core.sv @@
// MIMO multipath channel FIR core: one complex multiply-accumulate unit reads
// one tap word and one history row per cycle from two synchronous memories.
// Depends on mmcf_pkg, mmcf_chan_if, mmcf_mac and mmcf_scale.
//
// A tap word (mode 0) is written straight into the tap memory. A sample word is
// taken and then, for each active receive antenna, tx_count * tap_count terms
// are multiplied and accumulated, the unit drains, the sum is scaled and the result
// is handed over. The one shared multiply-accumulate unit sets the pace: no new
// word is taken until the last result of the current one is in the output register.
// The sample history is not swept on a frame start: a fill count marks how
// many instants are valid, and older rows read as zero. The user must write
// configuration only while the core is idle; the core does not enforce this.
// Taps never loaded read as garbage.
module mimo_multipath_channel_fir_core #(
    parameter int MAX_TX   = 4,
    parameter int MAX_RX   = 4,
    parameter int MAX_TAPS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mmcf_in_if.sink           i_in,
    mmcf_out_if.source        o_out,
    mmcf_cfg_if.sink          i_cfg
);
    import mmcf_pkg::*;

    localparam int TAP_DEPTH = MAX_TX * MAX_RX * MAX_TAPS;
    localparam int TAW   = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
    localparam int PW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int HW    = 2 * SMP_W * MAX_TX;
    localparam int ACC_W = 33 + $clog2(MAX_TX * MAX_TAPS);
    localparam logic [PW:0] TAPS_EXT = (PW+1)'(MAX_TAPS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]     r_state;
    logic [2:0]     r_tx_cnt, r_rx_cnt;
    logic [CW-1:0]  r_tap_cnt, r_fill;
    logic [15:0]    r_gain;
    logic [PW-1:0]  r_wp, n_wp, r_l;
    logic [1:0]     r_r, r_t, r_t1;
    logic           r_v1, r_z1;
    logic           r_out_valid;
    t_out_word      r_out_word;

    logic [2*SMP_W-1:0] r_tap_mem [TAP_DEPTH];
    logic [HW-1:0]      r_hist_mem [MAX_TAPS];
    logic [2*SMP_W-1:0] r_tap_q;
    logic [HW-1:0]      r_hist_q;

    logic            w_accept, w_smp_accept, w_tap_we;
    logic [TAW-1:0]  w_tap_rd;
    logic [PW-1:0]   w_hist_rd;
    logic [12:0]     w_tap_lin;
    logic [HW-1:0]   w_row;
    logic            w_l_last, w_t_last, w_r_last, w_drained, w_out_load;
    logic [CW-1:0]   w_fill_next;
    t_mac_ctl        w_mac_ctl;
    t_cplx           w_x, w_c;
    logic signed [ACC_W-1:0] w_acc_re, w_acc_im;
    logic            w_mac_busy, w_scl_done;
    logic signed [SMP_W-1:0] w_scl_re, w_scl_im;
    logic [5:0]      w_cfg_tap;
    logic [2:0]      w_cfg_cnt;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_smp_accept = w_accept &&
        (i_in.data.mode == MODE_FIRST || i_in.data.mode == MODE_NEXT);
    assign w_tap_we = w_accept && (i_in.data.mode == MODE_TAP) &&
        ({4'b0, i_in.data.tap_addr} < 13'(TAP_DEPTH));

    // Next history row pointer and fill count
    always_comb begin
        if (i_in.data.mode == MODE_FIRST) begin
            n_wp        = '0;
            w_fill_next = CW'(1);
        end else begin
            n_wp        = (r_wp == PW'(MAX_TAPS - 1)) ? '0 : r_wp + PW'(1);
            w_fill_next = (r_fill == CW'(MAX_TAPS)) ? r_fill : r_fill + CW'(1);
        end
    end

    // Pack the transmit samples of one instant into a history row
    always_comb begin
        t_cplx smp [4];
        smp[0] = '{re: i_in.data.tx0_re, im: i_in.data.tx0_im};
        smp[1] = '{re: i_in.data.tx1_re, im: i_in.data.tx1_im};
        smp[2] = '{re: i_in.data.tx2_re, im: i_in.data.tx2_im};
        smp[3] = '{re: i_in.data.tx3_re, im: i_in.data.tx3_im};
        w_row  = '0;
        for (int t = 0; t < MAX_TX; t++) begin
            w_row[t*2*SMP_W +: 2*SMP_W] = smp[t];
        end
    end

    // Read addresses of the current term
    assign w_tap_lin = (13'(r_t) * 13'(MAX_RX) + 13'(r_r)) * 13'(MAX_TAPS) + 13'(r_l);
    assign w_tap_rd  = TAW'(w_tap_lin);
    assign w_hist_rd = (r_wp >= r_l) ? (r_wp - r_l) :
                       PW'({1'b0, r_wp} + TAPS_EXT - {1'b0, r_l});

    // Tap and history memories with registered read ports
    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            r_tap_mem[TAW'(i_in.data.tap_addr)] <= {i_in.data.tap_re, i_in.data.tap_im};
        end
        r_tap_q <= r_tap_mem[w_tap_rd];
    end

    always_ff @(posedge i_clk) begin
        if (w_smp_accept) begin
            r_hist_mem[n_wp] <= w_row;
        end
        r_hist_q <= r_hist_mem[w_hist_rd];
    end

    assign w_l_last  = (r_l == PW'(r_tap_cnt - CW'(1)));
    assign w_t_last  = (r_t == 2'(r_tx_cnt - 3'd1));
    assign w_r_last  = (r_r == 2'(r_rx_cnt - 3'd1));
    assign w_drained = (r_state == ST_DRAIN) && !r_v1 && !w_mac_busy;
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);

    // Hold the lane and zero flag alongside the memory read
    always_ff @(posedge i_clk) begin
        r_t1 <= r_t;
        r_z1 <= (CW'(r_l) >= r_fill);
    end

    assign w_x = r_hist_q[r_t1*2*SMP_W +: 2*SMP_W];
    assign w_c = r_tap_q;
    assign w_mac_ctl = '{clear: w_smp_accept || (w_out_load && !w_r_last),
                         valid: r_v1, zero: r_z1};

    mmcf_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_x      (w_x),
        .i_c      (w_c),
        .o_acc_re (w_acc_re),
        .o_acc_im (w_acc_im),
        .o_busy   (w_mac_busy)
    );

    mmcf_scale #(.ACC_W(ACC_W)) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_drained),
        .i_acc_re (w_acc_re),
        .i_acc_im (w_acc_im),
        .i_gain   (r_gain),
        .o_done   (w_scl_done),
        .o_re     (w_scl_re),
        .o_im     (w_scl_im)
    );

    assign w_cfg_cnt = i_cfg.data[2:0];
    assign w_cfg_tap = i_cfg.data[5:0];

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tx_cnt    <= 3'd1;
            r_rx_cnt    <= 3'd1;
            r_tap_cnt   <= CW'(1);
            r_gain      <= GAIN_UNITY;
            r_wp        <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
            r_r         <= '0;
            r_t         <= '0;
            r_l         <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.addr)
                    CFG_TX_COUNT: begin
                        r_tx_cnt <= (w_cfg_cnt == 3'd0) ? 3'd1 :
                                    (w_cfg_cnt > 3'(MAX_TX)) ? 3'(MAX_TX) : w_cfg_cnt;
                    end
                    CFG_RX_COUNT: begin
                        r_rx_cnt <= (w_cfg_cnt == 3'd0) ? 3'd1 :
                                    (w_cfg_cnt > 3'(MAX_RX)) ? 3'(MAX_RX) : w_cfg_cnt;
                    end
                    CFG_TAP_COUNT: begin
                        r_tap_cnt <= (w_cfg_tap == 6'd0) ? CW'(1) :
                                     ({3'b0, w_cfg_tap} > 9'(MAX_TAPS)) ? CW'(MAX_TAPS) :
                                     CW'(w_cfg_tap);
                    end
                    CFG_GAIN: begin
                        r_gain <= (i_cfg.data > GAIN_UNITY) ? GAIN_UNITY : i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end

            r_v1 <= (r_state == ST_RUN);
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_smp_accept) begin
                        r_wp    <= n_wp;
                        r_fill  <= w_fill_next;
                        r_r     <= '0;
                        r_t     <= '0;
                        r_l     <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    // Advance tap, then transmit antenna
                    if (w_l_last) begin
                        r_l <= '0;
                        if (w_t_last) begin
                            r_t     <= '0;
                            r_state <= ST_DRAIN;
                        end else begin
                            r_t <= r_t + 2'd1;
                        end
                    end else begin
                        r_l <= r_l + PW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (w_drained) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_scl_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        if (w_r_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_r     <= r_r + 2'd1;
                            r_state <= ST_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word <= '{rx_index: r_r, rx_re: w_scl_re, rx_im: w_scl_im,
                            last: w_r_last};
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

endmodule

@@ hdl/mmcf_checker.sv @@
// Port-level checks of the MIMO channel FIR core, bound to the top level.
// Depends on mmcf_pkg and mimo_multipath_channel_fir_core_macros.svh.
`include "mimo_multipath_channel_fir_core_macros.svh"

module mmcf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_in_mode,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  mmcf_pkg::t_out_word i_out_word
);
    import mmcf_pkg::*;

    // A pending result word stays until taken
    `MMCF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // A stalled result word keeps its payload
    `MMCF_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_word), "result changed while stalled")

    // The core goes busy only after taking a sample word
    `MMCF_ASSERT(a_busy_cause, $fell(i_in_ready) |-> ($past(i_in_valid) && ($past(i_in_mode) == MODE_FIRST || $past(i_in_mode) == MODE_NEXT)), "busy without a sample word")

    // The core frees up only once the last result of a word is loaded
    `MMCF_ASSERT(a_free_last, ($rose(i_in_ready) && $past(i_rst_n)) |-> (i_out_valid && i_out_word.last), "idle before last result")

endmodule

bind mimo_multipath_channel_fir_core mmcf_checker u_mmcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mode   (i_in.data.mode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data)
);

@@ tb/tb_top.sv @@
// Self-checking testbench of the MIMO multipath channel FIR core.
// Depends on mmcf_pkg, the channel interfaces and the core itself.
`timescale 1ns / 1ps

module tb_top;
    import mmcf_pkg::*;

    localparam int NTX      = 4;
    localparam int NRX      = 4;
    localparam int NTAPS    = 32;
    localparam int DEPTH    = NTX * NRX * NTAPS;
    localparam int SETTLE   = 700;
    localparam int LIMIT    = 4000000;

    logic i_clk;
    logic i_rst_n;

    mmcf_in_if  in_ch ();
    mmcf_out_if out_ch ();
    mmcf_cfg_if cfg_ch ();

    mimo_multipath_channel_fir_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the channel state
    logic signed [15:0] tap_re_m [DEPTH];
    logic signed [15:0] tap_im_m [DEPTH];
    bit                 tap_loaded [DEPTH];
    logic signed [15:0] hist_re_m [NTX][NTAPS];
    logic signed [15:0] hist_im_m [NTX][NTAPS];
    int unsigned        hist_ptr;
    int unsigned        act_tx, act_rx, act_taps, gain_m;

    t_out_word rx_expected [$];
    int        mismatches;
    int        send_idle;
    int        recv_stall;
    longint    cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Randomly stall the result side
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (rx_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word rx=%0d re=%0d im=%0d last=%0d",
                             got.rx_index, got.rx_re, got.rx_im, got.last);
            end else begin
                want = rx_expected.pop_front();
                if (got.rx_index !== want.rx_index || got.rx_re !== want.rx_re ||
                    got.rx_im !== want.rx_im || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected rx=%0d re=%0d im=%0d last=%0d, got rx=%0d re=%0d im=%0d last=%0d",
                                 want.rx_index, want.rx_re, want.rx_im, want.last,
                                 got.rx_index, got.rx_re, got.rx_im, got.last);
                end
            end
        end
    end

    function automatic int unsigned clamp_cnt(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Scale by gain, floor back to Q1.15, saturate
    function automatic logic signed [15:0] scale_sat(longint acc);
        longint q;
        q = (acc * longint'(gain_m)) >>> FRAC_SHIFT;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_TX_COUNT:  act_tx   = clamp_cnt(val[2:0], NTX);
            CFG_RX_COUNT:  act_rx   = clamp_cnt(val[2:0], NRX);
            CFG_TAP_COUNT: act_taps = clamp_cnt(val[5:0], NTAPS);
            CFG_GAIN:      gain_m   = (val > GAIN_UNITY) ? GAIN_UNITY : val;
            default: ;
        endcase
    endfunction

    // Update the mirror with one accepted word and queue its results
    function automatic void predict_rx(t_in_word w);
        logic signed [15:0] s_re [NTX];
        logic signed [15:0] s_im [NTX];
        longint acc_re, acc_im, xr, xi, cr, ci;
        int unsigned base, h;
        t_out_word o;
        s_re[0] = w.tx0_re; s_im[0] = w.tx0_im;
        s_re[1] = w.tx1_re; s_im[1] = w.tx1_im;
        s_re[2] = w.tx2_re; s_im[2] = w.tx2_im;
        s_re[3] = w.tx3_re; s_im[3] = w.tx3_im;
        if (w.mode == MODE_TAP) begin
            tap_re_m[w.tap_addr] = w.tap_re;
            tap_im_m[w.tap_addr] = w.tap_im;
            return;
        end
        if (w.mode != MODE_FIRST && w.mode != MODE_NEXT) return;
        if (w.mode == MODE_FIRST) begin
            for (int t = 0; t < NTX; t++)
                for (int l = 0; l < NTAPS; l++) begin
                    hist_re_m[t][l] = '0;
                    hist_im_m[t][l] = '0;
                end
            hist_ptr = 0;
        end else begin
            hist_ptr = (hist_ptr + 1) % NTAPS;
        end
        for (int t = 0; t < NTX; t++) begin
            hist_re_m[t][hist_ptr] = s_re[t];
            hist_im_m[t][hist_ptr] = s_im[t];
        end
        for (int r = 0; r < act_rx; r++) begin
            acc_re = 0;
            acc_im = 0;
            for (int t = 0; t < act_tx; t++) begin
                base = (t * NRX + r) * NTAPS;
                for (int l = 0; l < act_taps; l++) begin
                    h  = (hist_ptr + NTAPS - l) % NTAPS;
                    xr = hist_re_m[t][h];
                    xi = hist_im_m[t][h];
                    cr = tap_re_m[base + l];
                    ci = tap_im_m[base + l];
                    acc_re += xr * cr - xi * ci;
                    acc_im += xr * ci + xi * cr;
                end
            end
            o.rx_index = r[1:0];
            o.rx_re    = scale_sat(acc_re);
            o.rx_im    = scale_sat(acc_im);
            o.last     = (r + 1 == act_rx);
            rx_expected.push_back(o);
        end
    endfunction

    function automatic logic [15:0] rnd_smp();
        case ($urandom_range(15))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return $urandom;
        endcase
    endfunction

    // Drive one word, wait for it to be taken
    task automatic send_word(t_in_word w);
        @(negedge i_clk);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.data  = w;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_rx(w);
    endtask

    task automatic send_tap(int unsigned addr, logic [15:0] re, logic [15:0] im);
        t_in_word w;
        w = '0;
        w.mode = MODE_TAP;
        w.tap_addr = addr[8:0];
        w.tap_re = re;
        w.tap_im = im;
        tap_loaded[addr] = 1'b1;
        send_word(w);
    endtask

    task automatic send_sample(logic [1:0] mode, bit fixed_val, logic [15:0] v);
        t_in_word w;
        w = '0;
        w.mode = mode;
        w.tap_addr = $urandom;
        w.tap_re = $urandom;
        w.tap_im = $urandom;
        w.tx0_re = fixed_val ? v : rnd_smp();
        w.tx0_im = fixed_val ? v : rnd_smp();
        w.tx1_re = fixed_val ? v : rnd_smp();
        w.tx1_im = fixed_val ? v : rnd_smp();
        w.tx2_re = fixed_val ? v : rnd_smp();
        w.tx2_im = fixed_val ? v : rnd_smp();
        w.tx3_re = fixed_val ? v : rnd_smp();
        w.tx3_im = fixed_val ? v : rnd_smp();
        send_word(w);
    endtask

    // Load every tap the current setting reads that was never written, or all of them on reload
    task automatic fill_taps(bit reload, bit fixed_val, logic [15:0] re, logic [15:0] im);
        int unsigned a;
        for (int t = 0; t < act_tx; t++)
            for (int r = 0; r < act_rx; r++)
                for (int l = 0; l < act_taps; l++) begin
                    a = (t * NRX + r) * NTAPS + l;
                    if (reload || !tap_loaded[a])
                        send_tap(a, fixed_val ? re : rnd_smp(), fixed_val ? im : rnd_smp());
                end
    endtask

    // Drop valid and hold until all results are in
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (rx_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.addr  = idx;
        cfg_ch.data  = val;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_all(int tx, int rx, int taps, int g);
        write_reg(CFG_TX_COUNT, tx);
        write_reg(CFG_RX_COUNT, rx);
        write_reg(CFG_TAP_COUNT, taps);
        write_reg(CFG_GAIN, g);
    endtask

    // Reset values: one pair, one tap, unity gain
    task automatic test_defaults();
        send_tap(0, 16'h7fff, 16'h0000);
        send_sample(MODE_FIRST, 1, 16'h7fff);
        send_sample(MODE_NEXT, 1, 16'h8000);
        send_sample(MODE_NEXT, 0, 0);
    endtask

    // All antenna pairs with extreme taps and samples, driving saturation
    task automatic test_extremes();
        set_all(4, 4, 1, 32768);
        fill_taps(1, 1, 16'h8000, 16'h7fff);
        send_sample(MODE_FIRST, 1, 16'h8000);
        send_sample(MODE_NEXT, 1, 16'h8000);
        send_sample(MODE_NEXT, 1, 16'h7fff);
        send_sample(MODE_NEXT, 1, 16'h0000);
        send_sample(MODE_NEXT, 0, 0);
        send_sample(MODE_FIRST, 1, 16'h7fff);
    endtask

    // Clamped counts, saturated and zero gain, ignored index, mode three
    task automatic test_clamps();
        set_all(0, 0, 63, 16'hffff);
        fill_taps(0, 0, 0, 0);
        write_reg(3'd5, 16'h0002);
        write_reg(3'd7, 16'hffff);
        send_sample(MODE_NEXT, 0, 0);
        send_sample(2'd3, 0, 0);
        send_sample(MODE_FIRST, 1, 16'h8000);
        set_all(7, 7, 0, 0);
        send_sample(MODE_NEXT, 1, 16'h7fff);
        write_reg(CFG_GAIN, 16'd32769);
        send_sample(2'd3, 0, 0);
        send_sample(MODE_NEXT, 0, 0);
    endtask

    // Well-formed frames with random content, some tap updates and noise
    task automatic test_random(int n, int idle, int stall, int tx, int rx, int taps, int g,
                               bit pause_mid);
        int pick;
        set_all(tx, rx, taps, g);
        send_idle  = idle;
        recv_stall = stall;
        fill_taps(0, 0, 0, 0);
        send_sample(MODE_FIRST, 0, 0);
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) drain();
            pick = $urandom_range(99);
            if (pick < 6)       send_sample(2'd3, 0, 0);
            else if (pick < 14) send_tap($urandom_range(DEPTH - 1), rnd_smp(), rnd_smp());
            else if (pick < 22) send_sample(MODE_FIRST, 0, 0);
            else                send_sample(MODE_NEXT, 0, 0);
        end
        send_idle  = 0;
        recv_stall = 0;
    endtask

    initial begin
        cycles       = 0;
        mismatches   = 0;
        send_idle    = 0;
        recv_stall   = 0;
        hist_ptr     = 0;
        act_tx       = 1;
        act_rx       = 1;
        act_taps     = 1;
        gain_m       = 32768;
        for (int a = 0; a < DEPTH; a++) begin
            tap_re_m[a] = '0;
            tap_im_m[a] = '0;
            tap_loaded[a] = 1'b0;
        end
        for (int t = 0; t < NTX; t++)
            for (int l = 0; l < NTAPS; l++) begin
                hist_re_m[t][l] = '0;
                hist_im_m[t][l] = '0;
            end
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr  = '0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_extremes();
        test_clamps();
        test_random(6, 0, 0, 2, 3, 4, 20000, 0);
        test_random(6, 79, 0, 4, 1, 3, 32768, 1);
        test_random(6, 0, 79, 1, 4, 2, 12345, 0);
        test_random(6, 30, 30, 3, 2, 5, 32768, 0);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && rx_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ mimo_multipath_channel_fir_core.f @@
+incdir+hdl
hdl/mmcf_pkg.sv
hdl/mmcf_chan_if.sv
hdl/mmcf_mac.sv
hdl/mmcf_scale.sv
hdl/mimo_multipath_channel_fir_core.sv
hdl/mmcf_checker.sv
tb/tb_top.sv
